FILE: src/mhtq_pkg.sv
// Package for the min-heap timer queue: action, status and command codes,
// the controller-to-datapath command struct and the status struct.
// No dependencies.
`default_nettype none
package mhtq_pkg;

	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_ADJUST = 3'd1;
	localparam logic [2:0] ACT_FIRE   = 3'd2;
	localparam logic [2:0] ACT_EXPIRE = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// datapath operations issued by the controller
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LATCH    = 4'd1;  // capture input item, look up id
	localparam logic [3:0] OP_RD_I     = 4'd2;  // read slot cur
	localparam logic [3:0] OP_RD_P     = 4'd3;  // read parent of cur
	localparam logic [3:0] OP_RD_L     = 4'd4;  // read left child of cur
	localparam logic [3:0] OP_RD_R     = 4'd5;  // read right child of cur
	localparam logic [3:0] OP_WR_NEW   = 4'd6;  // write new expiry and owner at cur, point id map at cur
	localparam logic [3:0] OP_SWAP_A   = 4'd7;  // write other entry into cur
	localparam logic [3:0] OP_SWAP_B   = 4'd8;  // write cur entry into other, cur <= other
	localparam logic [3:0] OP_RD_LAST  = 4'd9;  // read slot count-1
	localparam logic [3:0] OP_MOVE     = 4'd10; // write last entry into cur, drop count
	localparam logic [3:0] OP_DROP     = 4'd11; // remove entry at cur (id absent, count-1)
	localparam logic [3:0] OP_CLEAR    = 4'd12;
	localparam logic [3:0] OP_APPEND   = 4'd13; // cur <= count, mark id present, count+1
	localparam logic [3:0] OP_RD_TOP   = 4'd14;
	localparam logic [3:0] OP_SEL      = 4'd15; // cur <= slot of input id, owner <= input id

	typedef struct packed {
		logic [3:0] op;
	} mhtq_cmd_t;

	typedef struct packed {
		logic       id_ok;
		logic       present;
		logic       full;
		logic       empty;
		logic       has_parent;    // cur > 0
		logic       has_left;      // left child exists
		logic       has_right;
		logic       cur_lt_oth;    // entry at cur strictly earlier than other
		logic       oth_lt_cur;
		logic       moved_down;    // cur moved below start
		logic       is_last;       // cur is the last slot
		logic       top_due;       // top expiry minus now not positive
		logic [2:0] action;
	} mhtq_stat_t;

endpackage
`default_nettype wire

FILE: src/min_heap_timer_queue.sv
// Top level of the min-heap timer queue: controller plus datapath and the
// output packing. Depends on mhtq_pkg, mhtq_ctrl and mhtq_datapath.
// Usage:
//   s_axis carries one item: action, timer id, timeout and current time.
//   m_axis returns zero or more fired results (kind 0, fired id) and then
//   one status result (kind 1, tlast high) with has_next, wait and status.
//   One item at a time: s_axis_tready is high only when the block is idle.
//   An add or adjust sifts its entry down or up the heap; fire and expire
//   also re-sift the entry moved into each removed timer's slot.
//   When m_axis_tready is low the result holds and the block waits.
//   Reset empties the queue and marks every id absent; no clearing pass.
`default_nettype none
module min_heap_timer_queue import mhtq_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int ID_COUNT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// action[2:0], timer_id[10:3], timeout_ms[41:11], current_time[73:42]
	input  wire logic [79:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// fired_id[7:0], has_next[8], next_wait_ms[39:9], status[41:40]
	output logic [47:0]      m_axis_tdata,
	// kind
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);
	mhtq_cmd_t  cmd;
	mhtq_stat_t stat;
	logic kind, top_fire, has_next;
	logic [1:0] st;
	logic [7:0] top_owner, fid;
	logic [30:0] wait_ms;

	mhtq_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_kind(kind), .out_status(st), .out_top_fire(top_fire),
		.cmd, .stat
	);

	mhtq_datapath #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_action(s_axis_tdata[2:0]), .in_id(s_axis_tdata[10:3]),
		.in_timeout(s_axis_tdata[41:11]), .in_now(s_axis_tdata[73:42]),
		.top_owner, .has_next, .next_wait(wait_ms)
	);

	// fired id is the owner at cur: the addressed id on fire, the top owner on expire
	assign fid = top_owner;
	assign m_axis_tuser = kind;
	assign m_axis_tlast = kind;
	assign m_axis_tdata = kind ? {6'd0, st, wait_ms, has_next, 8'd0}
	                           : {6'd0, 2'd0, 31'd0, 1'b0, fid};

	logic unused_tf;
	assign unused_tf = top_fire ^ (|s_axis_tdata[79:74]);

	a_single_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind |-> st != 2'd3) else $error("bad status code");
	a_fired_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !kind |-> !m_axis_tlast) else $error("fired item marked last");
endmodule
`default_nettype wire

FILE: src/mhtq_datapath.sv
// Datapath of the timer queue: heap memories, id maps, slot pointers and
// the compare logic. Depends on mhtq_pkg; driven by mhtq_ctrl.
`default_nettype none
module mhtq_datapath import mhtq_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int ID_COUNT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mhtq_cmd_t   cmd,
	output mhtq_stat_t       stat,
	input  wire logic [2:0]  in_action,
	input  wire logic [7:0]  in_id,
	input  wire logic [30:0] in_timeout,
	input  wire logic [31:0] in_now,
	output logic [7:0]       top_owner,
	output logic             has_next,
	output logic [30:0]      next_wait
);
	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int RW = IW + 1;

	logic [31:0] exp_mem [CAPACITY];
	logic [IW-1:0] own_mem [CAPACITY];
	logic [SW-1:0] slot_mem [ID_COUNT];
	logic [ID_COUNT-1:0] present_q;

	logic [2:0]    act_q;
	logic [RW-1:0] id_q;
	logic [31:0]   now_q, expiry_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] cur_q, start_q, oth_q;
	logic [31:0]   cur_exp_q, oth_exp_q, l_exp_q;
	logic [IW-1:0] cur_own_q, oth_own_q;
	logic [SW-1:0] slot_rd_q;

	logic [SW:0] left_w, right_w;
	logic [SW-1:0] rd_addr;
	logic [31:0] rd_exp;
	logic [IW-1:0] rd_own;
	logic [31:0] d_top;
	logic id_ok;

	assign left_w  = {cur_q, 1'b1};
	assign right_w = {cur_q, 1'b0} + (SW+1)'(2);
	assign id_ok   = id_q < RW'(ID_COUNT);

	always_comb begin
		unique case (cmd.op)
			OP_RD_P:    rd_addr = SW'((cur_q - 1'b1) >> 1);
			OP_RD_L:    rd_addr = left_w[SW-1:0];
			OP_RD_R:    rd_addr = right_w[SW-1:0];
			OP_RD_LAST: rd_addr = SW'(count_q - 1'b1);
			OP_RD_TOP:  rd_addr = '0;
			default:    rd_addr = cur_q;
		endcase
	end
	assign rd_exp = exp_mem[rd_addr];
	assign rd_own = own_mem[rd_addr];

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_WR_NEW: begin
				exp_mem[cur_q] <= expiry_q;
				own_mem[cur_q] <= id_q[IW-1:0];
				slot_mem[id_q[IW-1:0]] <= cur_q;
			end
			OP_SWAP_A: begin
				exp_mem[cur_q] <= oth_exp_q;
				own_mem[cur_q] <= oth_own_q;
				slot_mem[oth_own_q] <= cur_q;
			end
			OP_SWAP_B: begin
				exp_mem[oth_q] <= cur_exp_q;
				own_mem[oth_q] <= cur_own_q;
				slot_mem[cur_own_q] <= oth_q;
			end
			OP_MOVE: begin
				exp_mem[cur_q] <= oth_exp_q;
				own_mem[cur_q] <= oth_own_q;
				slot_mem[oth_own_q] <= cur_q;
			end
			default: ;
		endcase
		if (cmd.op == OP_LATCH)
			slot_rd_q <= slot_mem[IW'(in_id)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			count_q   <= '0;
			act_q     <= '0;
			id_q      <= '0;
			now_q     <= '0;
			expiry_q  <= '0;
			cur_q     <= '0;
			start_q   <= '0;
			oth_q     <= '0;
			cur_exp_q <= '0;
			oth_exp_q <= '0;
			l_exp_q   <= '0;
			cur_own_q <= '0;
			oth_own_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_LATCH: begin
					act_q    <= in_action;
					id_q     <= RW'(in_id);
					now_q    <= in_now;
					expiry_q <= in_now + {1'b0, in_timeout};
				end
				OP_RD_I: begin
					// first read of a resift: entry at cur, and cur recorded as start
					cur_exp_q <= rd_exp;
					cur_own_q <= rd_own;
					start_q   <= cur_q;
				end
				OP_RD_P: begin
					oth_q     <= SW'((cur_q - 1'b1) >> 1);
					oth_exp_q <= rd_exp;
					oth_own_q <= rd_own;
				end
				OP_RD_L: begin
					l_exp_q   <= rd_exp;
					oth_q     <= left_w[SW-1:0];
					oth_exp_q <= rd_exp;
					oth_own_q <= rd_own;
				end
				OP_RD_R: begin
					// keep right only when strictly earlier than left
					if (rd_exp - l_exp_q >= 32'h8000_0000) begin
						oth_q     <= right_w[SW-1:0];
						oth_exp_q <= rd_exp;
						oth_own_q <= rd_own;
					end
				end
				OP_RD_LAST: begin
					oth_exp_q <= rd_exp;
					oth_own_q <= rd_own;
				end
				OP_SWAP_B: cur_q <= oth_q;
				OP_MOVE: begin
					count_q   <= count_q - 1'b1;
					present_q[cur_own_q] <= 1'b0;
				end
				OP_DROP: begin
					count_q   <= count_q - 1'b1;
					present_q[cur_own_q] <= 1'b0;
				end
				OP_CLEAR: begin
					count_q   <= '0;
					present_q <= '0;
				end
				OP_APPEND: begin
					cur_q     <= SW'(count_q);
					count_q   <= count_q + 1'b1;
					present_q[id_q[IW-1:0]] <= 1'b1;
				end
				OP_RD_TOP: begin
					cur_q     <= '0;
					cur_exp_q <= rd_exp;
					cur_own_q <= rd_own;
				end
				// the slot of a present id holds that id as owner
				OP_SEL: begin
					cur_q     <= slot_rd_q;
					cur_own_q <= id_q[IW-1:0];
				end
				default: ;
			endcase
		end
	end

	assign d_top = cur_exp_q - now_q;

	always_comb begin
		stat.id_ok      = id_ok;
		stat.present    = id_ok && present_q[id_q[IW-1:0]];
		stat.full       = count_q >= CW'(CAPACITY);
		stat.empty      = count_q == '0;
		stat.has_parent = cur_q != '0;
		stat.has_left   = {1'b0, left_w} < (SW+2)'(count_q);
		stat.has_right  = {1'b0, right_w} < (SW+2)'(count_q);
		stat.cur_lt_oth = cur_exp_q[31:0] - oth_exp_q >= 32'h8000_0000;
		stat.oth_lt_cur = oth_exp_q - cur_exp_q >= 32'h8000_0000;
		stat.moved_down = cur_q > start_q;
		stat.is_last    = (SW+1)'(cur_q) == (SW+1)'(count_q - 1'b1);
		stat.top_due    = d_top == '0 || d_top[31];
		stat.action     = act_q;
	end

	assign top_owner = 8'(cur_own_q);
	assign has_next  = count_q != '0;
	assign next_wait = (count_q == '0 || d_top[31]) ? '0 : d_top[30:0];
endmodule
`default_nettype wire

FILE: src/mhtq_ctrl.sv
// Controller state machine for the timer queue: sequences reads, swaps and
// result emission on the datapath. Depends on mhtq_pkg.
`default_nettype none
module mhtq_ctrl import mhtq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_kind,
	output logic [1:0]      out_status,
	output logic            out_top_fire, // fired id is heap owner, not input id
	output mhtq_cmd_t       cmd,
	input  wire mhtq_stat_t stat
);
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DECIDE  = 5'd1;
	localparam logic [4:0] S_SETCUR  = 5'd2;
	localparam logic [4:0] S_WRNEW   = 5'd3;
	localparam logic [4:0] S_RS_I    = 5'd4;
	localparam logic [4:0] S_DN_L    = 5'd5;
	localparam logic [4:0] S_DN_R    = 5'd6;
	localparam logic [4:0] S_DN_CMP  = 5'd7;
	localparam logic [4:0] S_SWA     = 5'd8;
	localparam logic [4:0] S_SWB     = 5'd9;
	localparam logic [4:0] S_UP_P    = 5'd10;
	localparam logic [4:0] S_UP_CMP  = 5'd11;
	localparam logic [4:0] S_FIRE    = 5'd12;
	localparam logic [4:0] S_REM_I   = 5'd13;
	localparam logic [4:0] S_REM_L   = 5'd14;
	localparam logic [4:0] S_REM_MV  = 5'd15;
	localparam logic [4:0] S_TOP     = 5'd16;
	localparam logic [4:0] S_EXP_CHK = 5'd17;
	localparam logic [4:0] S_STATUS  = 5'd18;
	localparam logic [4:0] S_APPEND  = 5'd19;

	logic [4:0] state_q, state_d;
	logic [1:0] st_q, st_d;
	logic       up_q, up_d;     // current swap belongs to sift-up
	logic       exp_q, exp_d;   // removal is part of expire
	logic       top_q, top_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			up_q    <= 1'b0;
			exp_q   <= 1'b0;
			top_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			up_q    <= up_d;
			exp_q   <= exp_d;
			top_q   <= top_d;
		end
	end

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = state_q == S_FIRE || state_q == S_STATUS;
	assign out_kind     = state_q == S_STATUS;
	assign out_status   = st_q;
	assign out_top_fire = top_q;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		up_d    = up_q;
		exp_d   = exp_q;
		top_d   = top_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					st_d    = ST_OK;
					exp_d   = 1'b0;
					top_d   = 1'b0;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (stat.action)
					ACT_ADD: begin
						if (!stat.id_ok) begin
							st_d = ST_UNKNOWN; state_d = S_TOP;
						end else if (stat.present) begin
							state_d = S_SETCUR;
						end else if (stat.full) begin
							st_d = ST_FULL; state_d = S_TOP;
						end else begin
							state_d = S_APPEND;
						end
					end
					ACT_ADJUST: begin
						if (!stat.present) begin
							st_d = ST_UNKNOWN; state_d = S_TOP;
						end else state_d = S_SETCUR;
					end
					ACT_FIRE: begin
						if (!stat.present) begin
							st_d = ST_UNKNOWN; state_d = S_TOP;
						end else begin
							cmd.op = OP_SEL; state_d = S_FIRE;
						end
					end
					ACT_EXPIRE: begin
						exp_d = 1'b1; state_d = S_TOP;
					end
					ACT_CLEAR: begin
						cmd.op = OP_CLEAR; state_d = S_TOP;
					end
					default: state_d = S_TOP;
				endcase
			end
			S_APPEND: begin
				cmd.op = OP_APPEND; state_d = S_WRNEW;
			end
			S_SETCUR: begin
				cmd.op = OP_SEL; state_d = S_WRNEW;
			end
			S_WRNEW: begin
				cmd.op = OP_WR_NEW; state_d = S_RS_I;
			end
			S_RS_I: begin
				cmd.op = OP_RD_I; state_d = S_DN_L;
			end
			S_DN_L: begin
				if (stat.has_left) begin
					cmd.op = OP_RD_L;
					state_d = stat.has_right ? S_DN_R : S_DN_CMP;
				end else if (stat.moved_down) begin
					state_d = S_TOP;
				end else state_d = S_UP_P;
			end
			S_DN_R: begin
				cmd.op = OP_RD_R; state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (stat.cur_lt_oth) begin
					state_d = stat.moved_down ? S_TOP : S_UP_P;
				end else begin
					up_d = 1'b0; state_d = S_SWA;
				end
			end
			S_SWA: begin
				cmd.op = OP_SWAP_A; state_d = S_SWB;
			end
			S_SWB: begin
				cmd.op = OP_SWAP_B;
				state_d = up_q ? S_UP_P : S_DN_L;
			end
			S_UP_P: begin
				if (stat.has_parent) begin
					cmd.op = OP_RD_P; state_d = S_UP_CMP;
				end else state_d = S_TOP;
			end
			S_UP_CMP: begin
				if (stat.oth_lt_cur) state_d = S_TOP;
				else begin
					up_d = 1'b1; state_d = S_SWA;
				end
			end
			S_FIRE: begin
				if (out_ready) state_d = S_REM_I;
			end
			S_REM_I: begin
				cmd.op = OP_RD_I; state_d = S_REM_L;
			end
			S_REM_L: begin
				if (stat.is_last) begin
					cmd.op = OP_DROP; state_d = S_TOP;
				end else begin
					cmd.op = OP_RD_LAST; state_d = S_REM_MV;
				end
			end
			S_REM_MV: begin
				cmd.op = OP_MOVE; state_d = S_RS_I;
			end
			S_TOP: begin
				cmd.op = OP_RD_TOP;
				state_d = exp_q ? S_EXP_CHK : S_STATUS;
			end
			S_EXP_CHK: begin
				if (!stat.empty && stat.top_due) begin
					top_d = 1'b1; state_d = S_FIRE;
				end else state_d = S_STATUS;
			end
			S_STATUS: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
